>>> rtl/i2cm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types, codes and constants of the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [7:0]  HALF_PERIOD_RST   = 8'd5;
  localparam logic [7:0]  HALF_PERIOD_ZERO  = 8'd5;   // substitute for a zero half period
  localparam logic [15:0] STRETCH_LIMIT_RST = 16'd2000;
  localparam logic [7:0]  POLL_INTERVAL     = 8'd10;  // ticks between stretch checks
  localparam logic [2:0]  BYTE_MSB          = 3'd7;

  localparam int DEF_CMD_QUEUE_DEPTH = 4;
  localparam int DEF_RES_QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    REG_HALF_PERIOD   = 2'd0,
    REG_STRETCH_LIMIT = 2'd1,
    REG_SCL_READBACK  = 2'd2,
    REG_SDA_READBACK  = 2'd3
  } i2cm_reg_e;

  typedef enum logic [2:0] {
    OP_START  = 3'd0,
    OP_RSTART = 3'd1,
    OP_WRITE  = 3'd2,
    OP_READ   = 3'd3,
    OP_STOP   = 3'd4
  } i2cm_op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NAK     = 2'd1,
    ST_TIMEOUT = 2'd2
  } i2cm_status_e;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_ST_HI    = 5'd1,
    PH_ST_POLL  = 5'd2,
    PH_ST_SDA0  = 5'd3,
    PH_ST_SCLLO = 5'd4,
    PH_RS_A     = 5'd5,
    PH_RS_HI    = 5'd6,
    PH_SP_A     = 5'd7,
    PH_SP_HI    = 5'd8,
    PH_SP_POLL  = 5'd9,
    PH_SP_SDA1  = 5'd10,
    PH_DONE     = 5'd11,
    PH_WR_BIT   = 5'd12,
    PH_WR_HI    = 5'd13,
    PH_WR_POLL  = 5'd14,
    PH_WR_LO    = 5'd15,
    PH_WR_AREL  = 5'd16,
    PH_WR_AHI   = 5'd17,
    PH_WR_APOLL = 5'd18,
    PH_WR_ALO   = 5'd19,
    PH_RD_HI    = 5'd20,
    PH_RD_POLL  = 5'd21,
    PH_RD_LO    = 5'd22,
    PH_RD_ACK   = 5'd23,
    PH_RD_AHI   = 5'd24,
    PH_RD_APOLL = 5'd25,
    PH_RD_ALO   = 5'd26,
    PH_RD_END   = 5'd27
  } i2cm_phase_e;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] operation;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       scl_in;
    logic       sda_in;
  } i2cm_in_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       cmd_ready;
    logic       done_res;
    logic [7:0] rx_byte;
    logic [1:0] status;
  } i2cm_out_t;

  // classified tick as it travels from front to back
  typedef struct packed {
    logic       go;
    i2cm_op_e   op;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       scl_in;
    logic       sda_in;
  } i2cm_tick_t;

  typedef struct packed {
    logic [7:0]  half_period_us;
    logic [15:0] stretch_limit_us;
    logic        scl_readback_enable;
    logic        sda_readback_enable;
  } i2cm_cfg_t;

  typedef struct packed {
    i2cm_phase_e phase;
    logic [2:0]  bit_count;
    logic [7:0]  shift_reg;
    logic [7:0]  delay_count;
    logic [15:0] stretch_waited;
    logic        scl_drive;
    logic        sda_drive;
    logic [1:0]  last_status;
    logic        ack_hold;
    logic [7:0]  rx_hold;
    logic        done;
  } i2cm_eng_t;

endpackage

>>> rtl/i2cm_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_fifo
// Small first-in first-out queue with full/empty flags.
// ----------------------------------------------------------------------------
module i2cm_fifo #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> rtl/i2cm_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_regs
// APB-style configuration registers: timing and readback enables.
// ----------------------------------------------------------------------------
module i2cm_regs
  import i2cm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output i2cm_cfg_t             cfg
);

  i2cm_cfg_t cfg_r, cfg_nxt;
  i2cm_reg_e idx;
  logic      wr_en;

  assign pready = 1'b1;
  assign idx    = i2cm_reg_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_HALF_PERIOD:   cfg_nxt.half_period_us      = pwdata[7:0];
        REG_STRETCH_LIMIT: cfg_nxt.stretch_limit_us    = pwdata[15:0];
        REG_SCL_READBACK:  cfg_nxt.scl_readback_enable = pwdata[0];
        REG_SDA_READBACK:  cfg_nxt.sda_readback_enable = pwdata[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HALF_PERIOD:   prdata = {24'd0, cfg_r.half_period_us};
      REG_STRETCH_LIMIT: prdata = {16'd0, cfg_r.stretch_limit_us};
      REG_SCL_READBACK:  prdata = {31'd0, cfg_r.scl_readback_enable};
      REG_SDA_READBACK:  prdata = {31'd0, cfg_r.sda_readback_enable};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period_us      <= HALF_PERIOD_RST;
      cfg_r.stretch_limit_us    <= STRETCH_LIMIT_RST;
      cfg_r.scl_readback_enable <= 1'b1;
      cfg_r.sda_readback_enable <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> rtl/i2cm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_front
// Takes tick requests and decodes the command field into a queue entry.
// ----------------------------------------------------------------------------
module i2cm_front
  import i2cm_pkg::*;
(
  input  i2cm_in_t   in_item,
  input  logic       push,
  output logic       full,
  output logic       q_push,
  output i2cm_tick_t q_item,
  input  logic       q_full
);

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    q_item.go       = in_item.cmd_valid && (in_item.operation inside {[OP_START:OP_STOP]});
    q_item.tx_byte  = in_item.tx_byte;
    q_item.send_ack = in_item.send_ack;
    q_item.scl_in   = in_item.scl_in;
    q_item.sda_in   = in_item.sda_in;
    case (in_item.operation)
      OP_START:  q_item.op = OP_START;
      OP_RSTART: q_item.op = OP_RSTART;
      OP_WRITE:  q_item.op = OP_WRITE;
      OP_READ:   q_item.op = OP_READ;
      OP_STOP:   q_item.op = OP_STOP;
      default:   q_item.op = OP_START;   // undefined codes carry go low
    endcase
  end

endmodule

>>> rtl/i2cm_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus sequencer: one queued tick per cycle while the result queue has room, one result per tick.
// ----------------------------------------------------------------------------
module i2cm_engine
  import i2cm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  i2cm_cfg_t  cfg,
  input  i2cm_tick_t tick,
  input  logic       tick_empty,
  output logic       tick_pop,
  output logic       res_push,
  output i2cm_out_t  res,
  input  logic       res_full
);

  i2cm_eng_t eng_r, eng_nxt;
  i2cm_eng_t s0, s1, s2;

  // One sequencer step. Polls that see SCL high fall straight through to
  // the next step, so a tick runs at most two of these.
  function automatic i2cm_eng_t run_action(input i2cm_eng_t s_in, input i2cm_cfg_t c,
                                           input logic scl_in, input logic sda_in);
    i2cm_eng_t   s;
    logic [7:0]  half;
    logic        sda_bit;
    logic        scl_up;
    logic        over;
    logic [16:0] sum;
    logic [15:0] waited_sat;
    s          = s_in;
    half       = (c.half_period_us == '0) ? HALF_PERIOD_ZERO : c.half_period_us;
    sda_bit    = c.sda_readback_enable & sda_in;
    scl_up     = !c.scl_readback_enable || scl_in;
    over       = (s.stretch_waited >= c.stretch_limit_us);
    sum        = {1'b0, s.stretch_waited} + {9'd0, POLL_INTERVAL};
    waited_sat = sum[16] ? 16'hFFFF : sum[15:0];
    case (s.phase)
      PH_ST_HI, PH_RS_HI, PH_SP_HI, PH_WR_HI, PH_WR_AHI, PH_RD_HI, PH_RD_AHI: begin
        if (s.phase == PH_ST_HI || s.phase == PH_RD_HI) begin
          s.sda_drive = 1'b1;
        end
        s.scl_drive      = 1'b1;
        s.stretch_waited = '0;
        s.delay_count    = half;
        case (s.phase)
          PH_ST_HI, PH_RS_HI: s.phase = PH_ST_POLL;
          PH_SP_HI:           s.phase = PH_SP_POLL;
          PH_WR_HI:           s.phase = PH_WR_POLL;
          PH_WR_AHI:          s.phase = PH_WR_APOLL;
          PH_RD_HI:           s.phase = PH_RD_POLL;
          default:            s.phase = PH_RD_APOLL;
        endcase
      end
      PH_ST_POLL, PH_WR_POLL, PH_WR_APOLL, PH_RD_POLL, PH_RD_APOLL, PH_SP_POLL: begin
        if (scl_up || (over && s.phase == PH_SP_POLL)) begin
          // stop completes even after a stretch timeout
          case (s.phase)
            PH_ST_POLL: s.phase = PH_ST_SDA0;
            PH_WR_POLL: s.phase = PH_WR_LO;
            PH_WR_APOLL: begin
              s.bit_count = {2'b00, sda_bit};
              s.phase     = PH_WR_ALO;
            end
            PH_RD_POLL: begin
              s.shift_reg[s.bit_count] = s.shift_reg[s.bit_count] | sda_bit;
              s.phase                  = PH_RD_LO;
            end
            PH_RD_APOLL: s.phase = PH_RD_ALO;
            default:     s.phase = PH_SP_SDA1;
          endcase
        end else if (over) begin
          s.phase       = PH_IDLE;
          s.last_status = ST_TIMEOUT;
          s.done        = 1'b1;
        end else begin
          s.delay_count    = POLL_INTERVAL;
          s.stretch_waited = waited_sat;
        end
      end
      PH_ST_SDA0: begin
        s.sda_drive   = 1'b0;
        s.delay_count = half;
        s.phase       = PH_ST_SCLLO;
      end
      PH_ST_SCLLO: begin
        s.scl_drive   = 1'b0;
        s.delay_count = half;
        s.bit_count   = '0;
        s.phase       = PH_DONE;
      end
      PH_RS_A: begin
        s.sda_drive   = 1'b1;
        s.scl_drive   = 1'b0;
        s.delay_count = half;
        s.phase       = PH_RS_HI;
      end
      PH_SP_A: begin
        s.sda_drive   = 1'b0;
        s.scl_drive   = 1'b0;
        s.delay_count = half;
        s.phase       = PH_SP_HI;
      end
      PH_SP_SDA1: begin
        s.sda_drive   = 1'b1;
        s.delay_count = half;
        s.bit_count   = '0;
        s.phase       = PH_DONE;
      end
      PH_DONE: begin
        s.phase       = PH_IDLE;
        s.last_status = (s.bit_count == 3'd1) ? ST_NAK : ST_OK;
        s.done        = 1'b1;
      end
      PH_WR_BIT: begin
        s.sda_drive   = s.shift_reg[s.bit_count];
        s.delay_count = half;
        s.phase       = PH_WR_HI;
      end
      PH_WR_LO, PH_RD_LO: begin
        s.scl_drive   = 1'b0;
        s.delay_count = half;
        if (s.bit_count != '0) begin
          s.bit_count = s.bit_count - 1'b1;
          s.phase     = (s.phase == PH_WR_LO) ? PH_WR_BIT : PH_RD_HI;
        end else begin
          s.phase     = (s.phase == PH_WR_LO) ? PH_WR_AREL : PH_RD_ACK;
        end
      end
      PH_WR_AREL: begin
        s.sda_drive   = 1'b1;
        s.delay_count = half;
        s.phase       = PH_WR_AHI;
      end
      PH_WR_ALO: begin
        s.scl_drive   = 1'b0;
        s.delay_count = half;
        s.phase       = PH_DONE;
      end
      PH_RD_ACK: begin
        s.sda_drive   = !s.ack_hold;
        s.delay_count = half;
        s.phase       = PH_RD_AHI;
      end
      PH_RD_ALO: begin
        s.scl_drive   = 1'b0;
        s.delay_count = half;
        s.phase       = PH_RD_END;
      end
      PH_RD_END: begin
        s.sda_drive   = 1'b1;
        s.rx_hold     = s.shift_reg;
        s.phase       = PH_IDLE;
        s.last_status = ST_OK;
        s.done        = 1'b1;
      end
      default: s.phase = PH_IDLE;
    endcase
    return s;
  endfunction

  assign tick_pop = !tick_empty && !res_full;
  assign res_push = tick_pop;

  always_comb begin
    s0      = eng_r;
    s0.done = 1'b0;
    if (s0.phase == PH_IDLE) begin
      if (tick.go) begin
        s0.delay_count = '0;
        s0.bit_count   = '0;
        case (tick.op)
          OP_START:  s0.phase = PH_ST_HI;
          OP_RSTART: s0.phase = PH_RS_A;
          OP_WRITE: begin
            s0.shift_reg = tick.tx_byte;
            s0.bit_count = BYTE_MSB;
            s0.phase     = PH_WR_BIT;
          end
          OP_READ: begin
            s0.shift_reg = '0;
            s0.bit_count = BYTE_MSB;
            s0.ack_hold  = tick.send_ack;
            s0.phase     = PH_RD_HI;
          end
          default:   s0.phase = PH_SP_A;
        endcase
      end
    end else if (s0.delay_count != '0) begin
      s0.delay_count = s0.delay_count - 1'b1;
    end

    s1 = s0;
    if (s0.phase != PH_IDLE && s0.delay_count == '0) begin
      s1 = run_action(s0, cfg, tick.scl_in, tick.sda_in);
    end
    s2 = s1;
    if (s1.phase != PH_IDLE && s1.delay_count == '0) begin
      s2 = run_action(s1, cfg, tick.scl_in, tick.sda_in);
    end

    eng_nxt = tick_pop ? s2 : eng_r;

    res.scl_release = s2.scl_drive;
    res.sda_release = s2.sda_drive;
    res.cmd_ready   = (s2.phase == PH_IDLE);
    res.done_res    = s2.done;
    res.rx_byte     = s2.rx_hold;
    res.status      = s2.last_status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eng_r.phase          <= PH_IDLE;
      eng_r.bit_count      <= '0;
      eng_r.shift_reg      <= '0;
      eng_r.delay_count    <= '0;
      eng_r.stretch_waited <= '0;
      eng_r.scl_drive      <= 1'b1;
      eng_r.sda_drive      <= 1'b1;
      eng_r.last_status    <= ST_OK;
      eng_r.ack_hold       <= 1'b0;
      eng_r.rx_hold        <= '0;
      eng_r.done           <= 1'b0;
    end else begin
      eng_r <= eng_nxt;
    end
  end

endmodule

>>> rtl/i2c_master_byte_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Single-master open-drain I2C byte engine stepped once per bus tick.
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------
//   in_      | in_push / in_full   | i2cm_in_t  (command, sampled lines)
//   out_     | out_empty / out_pop | i2cm_out_t (line drives, status)
//   cfg_     | APB, pready = 1     | 4 regs at byte offsets 0,4,8,12
//
// One tick is taken per clock cycle while the result queue has room, and
// yields one result; a request is held in the tick queue, its result in the
// result queue. The sequencer runs at most two steps per tick.
// Reset is synchronous and needs no clearing pass. A full result queue holds
// the sequencer; the tick queue then fills and raises in_full.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine
  import i2cm_pkg::*;
#(
  parameter int CMD_QUEUE_DEPTH = DEF_CMD_QUEUE_DEPTH,
  parameter int RES_QUEUE_DEPTH = DEF_RES_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  i2cm_in_t              in_data,
  output logic                  out_empty,
  input  logic                  out_pop,
  output i2cm_out_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int TICK_W = $bits(i2cm_tick_t);
  localparam int RES_W  = $bits(i2cm_out_t);

  i2cm_cfg_t         cfg;
  i2cm_tick_t        tick_wr, tick_rd;
  logic [TICK_W-1:0] tick_rd_raw;
  logic              tick_push, tick_full, tick_empty, tick_pop;
  i2cm_out_t         res;
  logic [RES_W-1:0]  res_rd_raw;
  logic              res_push, res_full;

  i2cm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  i2cm_front u_front (
    .in_item (in_data),
    .push    (in_push),
    .full    (in_full),
    .q_push  (tick_push),
    .q_item  (tick_wr),
    .q_full  (tick_full)
  );

  i2cm_fifo #(
    .DEPTH (CMD_QUEUE_DEPTH),
    .WIDTH (TICK_W)
  ) u_tick_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (tick_push),
    .wr_data (tick_wr),
    .full    (tick_full),
    .rd_en   (tick_pop),
    .rd_data (tick_rd_raw),
    .empty   (tick_empty)
  );

  assign tick_rd = i2cm_tick_t'(tick_rd_raw);

  i2cm_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .tick       (tick_rd),
    .tick_empty (tick_empty),
    .tick_pop   (tick_pop),
    .res_push   (res_push),
    .res        (res),
    .res_full   (res_full)
  );

  i2cm_fifo #(
    .DEPTH (RES_QUEUE_DEPTH),
    .WIDTH (RES_W)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (out_pop),
    .rd_data (res_rd_raw),
    .empty   (out_empty)
  );

  assign out_data = i2cm_out_t'(res_rd_raw);

endmodule

>>> rtl/i2cm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks of the I2C master byte engine, bound to the top level.
// ----------------------------------------------------------------------------
module i2cm_checker
  import i2cm_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_full,
  input logic      out_empty,
  input logic      out_pop,
  input i2cm_out_t out_data
);

  // queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> $stable(out_data))
    else $error("waiting result changed");

  // a command always ends back in idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.done_res |-> out_data.cmd_ready)
    else $error("done pulse while busy");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_data.status != 2'd3)
    else $error("undefined status code");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the I2C master byte engine.
//
// Bus ticks are pushed through the input queue while a tick-accurate copy of
// the sequencer predicts the line drives, ready, done, received byte and
// status of every tick. Results are popped with random gaps and compared
// field by field in order. A simple bus model echoes SCL back and stretches
// it now and then; SDA is random. Directed tests cover each command, the
// register extremes, stretch timeouts and readback off; randomized
// transactions then run under several settings.
// ----------------------------------------------------------------------------
module tb;
  import i2cm_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int POLL_WAIT    = 0;
  localparam int POLL_HIGH    = 1;
  localparam int POLL_TIMEOUT = 2;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  i2cm_in_t              in_data = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  i2cm_out_t             out_data;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  i2c_master_byte_engine u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_data     (in_data),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // register mirror
  logic [7:0]  cfg_half   = HALF_PERIOD_RST;
  logic [15:0] cfg_limit  = STRETCH_LIMIT_RST;
  logic        cfg_scl_rb = 1'b1;
  logic        cfg_sda_rb = 1'b1;

  // sequencer mirror
  i2cm_phase_e eng_phase  = PH_IDLE;
  logic [3:0]  eng_bits   = '0;
  logic [7:0]  eng_shift  = '0;
  logic [7:0]  eng_delay  = '0;
  logic [15:0] eng_waited = '0;
  logic        eng_scl    = 1'b1;
  logic        eng_sda    = 1'b1;
  logic [1:0]  eng_status = ST_OK;
  logic        eng_ack    = 1'b0;
  logic [7:0]  eng_rx     = '0;
  logic        eng_done   = 1'b0;

  i2cm_out_t   bus_results_q[$];

  int ticks_sent;
  int reg_writes;
  int full_seen;
  int err_count;
  int stall_cycles;
  int done_by_status[4];
  int stretch_left;
  int stretch_permille;
  int line_noise_pct;
  int pop_hold;
  int pop_hold_req;
  bit sender_idle_on = 1'b1;
  bit recv_idle_on = 1'b1;
  bit busy_noise;
  bit bus_owned;

  // ---------------------------------------------------------------- predictor
  function automatic void wait_half();
    eng_delay = (cfg_half != 8'd0) ? cfg_half : HALF_PERIOD_ZERO;
  endfunction

  function automatic void release_scl();
    eng_scl = 1'b1;
    eng_waited = '0;
    wait_half();
  endfunction

  function automatic void finish_cmd(logic [1:0] st);
    eng_phase = PH_IDLE;
    eng_status = st;
    eng_done = 1'b1;
    done_by_status[st]++;
  endfunction

  function automatic int scl_poll(logic scl);
    logic [16:0] w;
    if (!cfg_scl_rb || scl) return POLL_HIGH;
    if (eng_waited >= cfg_limit) return POLL_TIMEOUT;
    eng_delay = POLL_INTERVAL;
    w = {1'b0, eng_waited} + 17'(POLL_INTERVAL);
    eng_waited = (w > 17'hFFFF) ? 16'hFFFF : w[15:0];
    return POLL_WAIT;
  endfunction

  function automatic void run_action(logic scl, logic sda);
    int   r;
    logic sda_bit;
    sda_bit = cfg_sda_rb & sda;
    case (eng_phase)
      PH_ST_HI: begin
        eng_sda = 1'b1; release_scl(); eng_phase = PH_ST_POLL;
      end
      PH_RS_HI: begin
        release_scl(); eng_phase = PH_ST_POLL;
      end
      PH_ST_POLL: begin
        r = scl_poll(scl);
        if (r == POLL_HIGH) eng_phase = PH_ST_SDA0;
        else if (r == POLL_TIMEOUT) finish_cmd(ST_TIMEOUT);
      end
      PH_ST_SDA0: begin
        eng_sda = 1'b0; wait_half(); eng_phase = PH_ST_SCLLO;
      end
      PH_ST_SCLLO: begin
        eng_scl = 1'b0; wait_half(); eng_bits = '0; eng_phase = PH_DONE;
      end
      PH_RS_A: begin
        eng_sda = 1'b1; eng_scl = 1'b0; wait_half(); eng_phase = PH_RS_HI;
      end
      PH_SP_A: begin
        eng_sda = 1'b0; eng_scl = 1'b0; wait_half(); eng_phase = PH_SP_HI;
      end
      PH_SP_HI: begin
        release_scl(); eng_phase = PH_SP_POLL;
      end
      PH_SP_POLL: begin
        // stop completes even when the stretch budget runs out
        if (scl_poll(scl) != POLL_WAIT) eng_phase = PH_SP_SDA1;
      end
      PH_SP_SDA1: begin
        eng_sda = 1'b1; wait_half(); eng_bits = '0; eng_phase = PH_DONE;
      end
      PH_DONE: finish_cmd(eng_bits == 4'd1 ? ST_NAK : ST_OK);
      PH_WR_BIT: begin
        eng_sda = eng_shift[eng_bits[2:0]]; wait_half(); eng_phase = PH_WR_HI;
      end
      PH_WR_HI: begin
        release_scl(); eng_phase = PH_WR_POLL;
      end
      PH_WR_POLL: begin
        r = scl_poll(scl);
        if (r == POLL_HIGH) eng_phase = PH_WR_LO;
        else if (r == POLL_TIMEOUT) finish_cmd(ST_TIMEOUT);
      end
      PH_WR_LO: begin
        eng_scl = 1'b0; wait_half();
        if (eng_bits > 0) begin
          eng_bits--; eng_phase = PH_WR_BIT;
        end else begin
          eng_phase = PH_WR_AREL;
        end
      end
      PH_WR_AREL: begin
        eng_sda = 1'b1; wait_half(); eng_phase = PH_WR_AHI;
      end
      PH_WR_AHI: begin
        release_scl(); eng_phase = PH_WR_APOLL;
      end
      PH_WR_APOLL: begin
        r = scl_poll(scl);
        if (r == POLL_HIGH) begin
          eng_bits = {3'b000, sda_bit}; eng_phase = PH_WR_ALO;
        end else if (r == POLL_TIMEOUT) begin
          finish_cmd(ST_TIMEOUT);
        end
      end
      PH_WR_ALO: begin
        eng_scl = 1'b0; wait_half(); eng_phase = PH_DONE;
      end
      PH_RD_HI: begin
        eng_sda = 1'b1; release_scl(); eng_phase = PH_RD_POLL;
      end
      PH_RD_POLL: begin
        r = scl_poll(scl);
        if (r == POLL_HIGH) begin
          eng_shift[eng_bits[2:0]] = eng_shift[eng_bits[2:0]] | sda_bit;
          eng_phase = PH_RD_LO;
        end else if (r == POLL_TIMEOUT) begin
          finish_cmd(ST_TIMEOUT);
        end
      end
      PH_RD_LO: begin
        eng_scl = 1'b0; wait_half();
        if (eng_bits > 0) begin
          eng_bits--; eng_phase = PH_RD_HI;
        end else begin
          eng_phase = PH_RD_ACK;
        end
      end
      PH_RD_ACK: begin
        eng_sda = ~eng_ack; wait_half(); eng_phase = PH_RD_AHI;
      end
      PH_RD_AHI: begin
        release_scl(); eng_phase = PH_RD_APOLL;
      end
      PH_RD_APOLL: begin
        r = scl_poll(scl);
        if (r == POLL_HIGH) eng_phase = PH_RD_ALO;
        else if (r == POLL_TIMEOUT) finish_cmd(ST_TIMEOUT);
      end
      PH_RD_ALO: begin
        eng_scl = 1'b0; wait_half(); eng_phase = PH_RD_END;
      end
      PH_RD_END: begin
        eng_sda = 1'b1; eng_rx = eng_shift; finish_cmd(ST_OK);
      end
      default: eng_phase = PH_IDLE;
    endcase
  endfunction

  function automatic i2cm_out_t predict_bus_tick(i2cm_in_t t);
    i2cm_out_t res;
    eng_done = 1'b0;
    if (eng_phase == PH_IDLE) begin
      // commands are taken only when idle; undefined codes fall through
      if (t.cmd_valid && t.operation <= OP_STOP) begin
        eng_delay = '0;
        eng_bits = '0;
        case (t.operation)
          OP_START:  eng_phase = PH_ST_HI;
          OP_RSTART: eng_phase = PH_RS_A;
          OP_WRITE: begin
            eng_shift = t.tx_byte; eng_bits = {1'b0, BYTE_MSB}; eng_phase = PH_WR_BIT;
          end
          OP_READ: begin
            eng_shift = '0; eng_bits = {1'b0, BYTE_MSB}; eng_ack = t.send_ack;
            eng_phase = PH_RD_HI;
          end
          default: eng_phase = PH_SP_A;
        endcase
      end
    end else if (eng_delay > 0) begin
      eng_delay--;
    end
    while (eng_phase != PH_IDLE && eng_delay == 0) run_action(t.scl_in, t.sda_in);
    res.scl_release = eng_scl;
    res.sda_release = eng_sda;
    res.cmd_ready   = (eng_phase == PH_IDLE);
    res.done_res    = eng_done;
    res.rx_byte     = eng_rx;
    res.status      = eng_status;
    return res;
  endfunction

  // ------------------------------------------------------------------ checker
  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    i2cm_out_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (bus_results_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result, expected none actual %h", $time, out_data);
      end else begin
        want = bus_results_q.pop_front();
        check_field("scl_release", 8'(want.scl_release), 8'(out_data.scl_release));
        check_field("sda_release", 8'(want.sda_release), 8'(out_data.sda_release));
        check_field("cmd_ready", 8'(want.cmd_ready), 8'(out_data.cmd_ready));
        check_field("done_res", 8'(want.done_res), 8'(out_data.done_res));
        check_field("rx_byte", want.rx_byte, out_data.rx_byte);
        check_field("status", 8'(want.status), 8'(out_data.status));
      end
    end
    if (rst_n && in_push && in_full) full_seen++;
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------- result side
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk) begin
    if (pop_hold_req > 0) begin
      pop_hold = pop_hold_req;
      pop_hold_req = 0;
    end
    if (pop_hold > 0) begin
      out_pop = 1'b0;
      pop_hold--;
    end else begin
      out_pop = 1'b1;
      if (recv_idle_on) pop_hold = gap_len();
    end
  end

  // ------------------------------------------------------------ register port
  task automatic apb_access(logic wr, i2cm_reg_e r, logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = wr;
    cfg_paddr = CFG_ADDR_W'({r, 2'b00});
    cfg_pwdata = wdata;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] reg_value(i2cm_reg_e r);
    case (r)
      REG_HALF_PERIOD:   return CFG_DATA_W'(cfg_half);
      REG_STRETCH_LIMIT: return CFG_DATA_W'(cfg_limit);
      REG_SCL_READBACK:  return CFG_DATA_W'(cfg_scl_rb);
      default:           return CFG_DATA_W'(cfg_sda_rb);
    endcase
  endfunction

  task automatic check_reg(i2cm_reg_e r);
    logic [CFG_DATA_W-1:0] got;
    apb_access(1'b0, r, '0, got);
    if (got !== reg_value(r)) begin
      err_count++;
      $display("%0t: register %s expected %0h actual %0h", $time, r.name(),
               reg_value(r), got);
    end
  endtask

  task automatic set_reg(i2cm_reg_e r, logic [CFG_DATA_W-1:0] v);
    logic [CFG_DATA_W-1:0] unused;
    apb_access(1'b1, r, v, unused);
    case (r)
      REG_HALF_PERIOD:   cfg_half = v[7:0];
      REG_STRETCH_LIMIT: cfg_limit = v[15:0];
      REG_SCL_READBACK:  cfg_scl_rb = v[0];
      default:           cfg_sda_rb = v[0];
    endcase
    reg_writes++;
    check_reg(r);
  endtask

  // ---------------------------------------------------------------- tick side
  // Lines as a simple bus sees them: SCL follows the master unless a target
  // is stretching it, SDA is whatever the target happens to drive.
  function automatic i2cm_in_t make_tick(logic valid, logic [2:0] op, logic [7:0] tx,
                                         logic ack);
    i2cm_in_t t;
    t.cmd_valid = valid;
    t.operation = op;
    t.tx_byte = tx;
    t.send_ack = ack;
    if (stretch_left == 0 && eng_scl && $urandom_range(0, 999) < stretch_permille)
      stretch_left = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 30)
                                                : $urandom_range(40, 300);
    if (stretch_left > 0) begin
      stretch_left--;
      t.scl_in = 1'b0;
    end else begin
      t.scl_in = eng_scl;
    end
    if ($urandom_range(0, 99) < line_noise_pct) t.scl_in = 1'($urandom);
    t.sda_in = 1'($urandom);
    return t;
  endfunction

  task automatic send_tick(i2cm_in_t t);
    int gap;
    gap = sender_idle_on ? gap_len() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_push = 1'b0;
    end
    @(negedge clk);
    in_push = 1'b1;
    in_data = t;
    do @(posedge clk); while (in_full);
    bus_results_q.push_back(predict_bus_tick(t));
    ticks_sent++;
  endtask

  // issues one command on an idle engine and runs ticks until it is idle again
  task automatic run_cmd(logic [2:0] op, logic [7:0] tx, logic ack);
    send_tick(make_tick(1'b1, op, tx, ack));
    if (op == OP_START || op == OP_RSTART) bus_owned = 1'b1;
    if (op == OP_STOP) bus_owned = 1'b0;
    while (eng_phase != PH_IDLE)
      send_tick(make_tick(busy_noise && ($urandom_range(0, 99) < 15),
                          3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom)));
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_push = 1'b0;
    while (bus_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(logic [7:0] hp, logic [15:0] limit, logic scl_rb, logic sda_rb);
    wait_all_results();
    set_reg(REG_HALF_PERIOD, CFG_DATA_W'(hp));
    set_reg(REG_STRETCH_LIMIT, CFG_DATA_W'(limit));
    set_reg(REG_SCL_READBACK, CFG_DATA_W'(scl_rb));
    set_reg(REG_SDA_READBACK, CFG_DATA_W'(sda_rb));
  endtask

  function automatic logic [2:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (!bus_owned) return (r < 85) ? OP_START : 3'($urandom_range(0, 7));
    if (r < 40) return OP_WRITE;
    if (r < 70) return OP_READ;
    if (r < 82) return OP_STOP;
    if (r < 90) return OP_RSTART;
    return 3'($urandom_range(0, 7));
  endfunction

  task automatic traffic(int n);
    int first;
    first = ticks_sent;
    while (ticks_sent - first < n) begin
      if ($urandom_range(0, 99) < 20)
        send_tick(make_tick(1'b0, 3'($urandom), 8'($urandom), 1'($urandom)));
      else
        run_cmd(pick_op(), 8'($urandom), 1'($urandom));
    end
  endtask

  // -------------------------------------------------------------------- tests
  task automatic test_register_access();
    for (int i = 0; i < 4; i++) check_reg(i2cm_reg_e'(i));
    for (int i = 0; i < 4; i++) set_reg(i2cm_reg_e'(i), '1);
    for (int i = 0; i < 4; i++) set_reg(i2cm_reg_e'(i), '0);
  endtask

  task automatic test_every_operation();
    configure(8'd1, STRETCH_LIMIT_RST, 1'b1, 1'b1);
    run_cmd(OP_START, 8'h00, 1'b0);
    run_cmd(OP_WRITE, 8'hFF, 1'b0);
    run_cmd(OP_WRITE, 8'h00, 1'b1);
    run_cmd(OP_READ, 8'hFF, 1'b1);
    run_cmd(OP_READ, 8'h00, 1'b0);
    run_cmd(OP_RSTART, 8'h00, 1'b0);
    run_cmd(OP_STOP, 8'h00, 1'b0);
    for (int op = OP_STOP + 1; op < 8; op++) run_cmd(3'(op), 8'hFF, 1'b1);
    // fresh requests while busy must be dropped
    busy_noise = 1'b1;
    run_cmd(OP_START, 8'h00, 1'b0);
    run_cmd(OP_WRITE, 8'h5A, 1'b0);
    run_cmd(OP_STOP, 8'h00, 1'b0);
    busy_noise = 1'b0;
  endtask

  task automatic test_half_period_extremes();
    configure(8'd0, STRETCH_LIMIT_RST, 1'b1, 1'b1);
    run_cmd(OP_START, 8'h00, 1'b0);
    run_cmd(OP_STOP, 8'h00, 1'b0);
    configure(8'd255, STRETCH_LIMIT_RST, 1'b1, 1'b1);
    run_cmd(OP_START, 8'h00, 1'b0);
  endtask

  task automatic test_stretch_timeouts();
    configure(8'd1, 16'd0, 1'b1, 1'b1);
    stretch_left = 8;
    run_cmd(OP_START, 8'h00, 1'b0);
    stretch_left = 0;
    run_cmd(OP_START, 8'h00, 1'b0);
    configure(8'd2, 16'd30, 1'b1, 1'b1);
    run_cmd(OP_READ, 8'h00, 1'b1);
    // a read that times out keeps the previous byte
    stretch_left = 100;
    run_cmd(OP_READ, 8'h00, 1'b0);
    stretch_left = 100;
    run_cmd(OP_WRITE, 8'hC3, 1'b0);
    stretch_left = 100;
    run_cmd(OP_STOP, 8'h00, 1'b0);
    stretch_left = 0;
  endtask

  task automatic test_readback_disabled();
    configure(8'd1, STRETCH_LIMIT_RST, 1'b0, 1'b0);
    stretch_left = 500;
    run_cmd(OP_START, 8'h00, 1'b0);
    run_cmd(OP_WRITE, 8'hA5, 1'b0);
    run_cmd(OP_READ, 8'h00, 1'b1);
    run_cmd(OP_STOP, 8'h00, 1'b0);
    stretch_left = 0;
  endtask

  task automatic test_full_backpressure();
    configure(8'd1, STRETCH_LIMIT_RST, 1'b1, 1'b1);
    sender_idle_on = 1'b0;
    pop_hold_req = 300;
    traffic(150);
    sender_idle_on = 1'b1;
  endtask

  task automatic random_phase(logic [7:0] hp, logic [15:0] limit, logic scl_rb,
                              logic sda_rb, int stretch, bit idle, int n);
    configure(hp, limit, scl_rb, sda_rb);
    stretch_permille = stretch;
    sender_idle_on = idle;
    recv_idle_on = idle;
    traffic(n);
  endtask

  task automatic test_random_traffic();
    busy_noise = 1'b1;
    line_noise_pct = 3;
    random_phase(8'd1, STRETCH_LIMIT_RST, 1'b1, 1'b1, 5, 1'b1, 40);
    random_phase(8'd2, 16'd0, 1'b1, 1'b1, 20, 1'b1, 40);
    random_phase(8'd3, 16'd40, 1'b0, 1'b1, 10, 1'b1, 40);
    random_phase(8'd1, 16'd100, 1'b1, 1'b0, 10, 1'b0, 40);
    random_phase(8'd0, 16'd300, 1'b1, 1'b1, 8, 1'b1, 40);
    random_phase(8'($urandom_range(1, 4)), 16'($urandom_range(0, 200)), 1'($urandom),
                 1'($urandom), 15, 1'b1, 40);
    random_phase(8'd1, 16'd60, 1'b1, 1'b1, 25, 1'b1, 40);
    busy_noise = 1'b0;
    line_noise_pct = 0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_register_access();
    test_every_operation();
    test_half_period_extremes();
    test_stretch_timeouts();
    test_readback_disabled();
    test_full_backpressure();
    test_random_traffic();

    wait_all_results();
    repeat (10) @(posedge clk);
    if (bus_results_q.size() != 0) begin
      err_count++;
      $display("%0t: %0d results never arrived", $time, bus_results_q.size());
    end
    $display("run covered %0d bus ticks; commands ended %0d ok, %0d nak, %0d timeout",
             ticks_sent, done_by_status[ST_OK], done_by_status[ST_NAK],
             done_by_status[ST_TIMEOUT]);
    $display("%0d register writes read back, input queue full on %0d cycles",
             reg_writes, full_seen);
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
